// ----- rtl/vob_pkg.sv -----
// Package for the voxel occupancy bitmap core.
// Holds sizing constants, function, status and register codes, and the state type.
// No dependencies.
package vob_pkg;

  localparam int AXIS_MAX   = 128;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int KEY_W      = 21;
  localparam int IN_KEY_W   = 22;
  localparam int AX_W       = $clog2(AXIS_MAX);
  localparam int SIZE_W     = 8;
  localparam int COORD_W    = 32;
  localparam int VOXELS     = AXIS_MAX * AXIS_MAX * AXIS_MAX;
  localparam int MAP_WORDS  = (VOXELS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = $clog2(MAP_WORDS);

  localparam logic [1:0] FN_CLEAR     = 2'd0;
  localparam logic [1:0] FN_MARK      = 2'd1;
  localparam logic [1:0] FN_QUERY_KEY = 2'd2;
  localparam logic [1:0] FN_QUERY_VOX = 2'd3;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_KEY_RANGE = 3'd1;
  localparam logic [2:0] STS_OUTSIDE   = 3'd2;
  localparam logic [2:0] STS_NOT_READY = 3'd3;
  localparam logic [2:0] STS_BAD_CFG   = 3'd4;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_SIZE_X   = 3'd3;
  localparam logic [2:0] REG_SIZE_Y   = 3'd4;
  localparam logic [2:0] REG_SIZE_Z   = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SUB,
    S_BOUND,
    S_SUM,
    S_LOOK,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ----- rtl/voxel_occupancy_bitmap_core.sv -----
// Voxel occupancy bitmap core: 3D grid bitmap in 64-bit RAM words, with clear, mark and queries.
// Depends on vob_pkg and vob_ram.
// Clear sweeps the RAM one word a cycle; mark and key query pass the look and read states,
// and voxel query passes the subtract, bound and sum states before them.
// One item at a time: the next beat is taken only after the result is handed to the output
// register and the state is back in idle. A config write holds input off until the settle
// counter has run down.
// Reset: flags cleared, registers to defaults, then a zeroing sweep of the RAM.
module voxel_occupancy_bitmap_core
  import vob_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key [21:0], vox_x [53:22], vox_y [85:54], vox_z [117:86], zero [119:118]
  input  logic [119:0] s_axis_tdata,
  // func [1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // occupied [0], linear_key [21:1], zero [23:22]
  output logic [23:0]  m_axis_tdata,
  // status [2:0]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  state_t state, state_next;

  logic signed [COORD_W-1:0] org_x, org_y, org_z;
  logic [SIZE_W-1:0]         size_x, size_y, size_z;
  logic [2*SIZE_W-1:0]       syz;
  logic [3*SIZE_W-1:0]       count;
  logic                      sizes_ok;
  logic [1:0]                settle;

  logic                      map_ready, load_failed;
  logic [1:0]                func;
  logic [IN_KEY_W-1:0]       key;
  logic                      last;
  logic signed [COORD_W-1:0] vx, vy, vz;
  logic signed [COORD_W:0]   rel_x, rel_y, rel_z;
  logic                      in_range;
  logic                      key_big;
  logic [AX_W+2*SIZE_W-1:0]  px;
  logic [AX_W+SIZE_W-1:0]    py;
  logic [AX_W-1:0]           pz;
  logic [KEY_W-1:0]          lk;
  logic                      clr_item;
  logic [ADDR_W-1:0]         sweep;

  logic                      res_occ;
  logic [2:0]                res_status;
  logic [KEY_W-1:0]          res_lkey;

  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]      mem_wdata, mem_rdata;
  logic                      in_beat, out_free, fail_new, rd_bit;
  logic [AX_W+2*SIZE_W:0]    idx_sum;

  assign cfg_ready = 1'b1;
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign fail_new  = load_failed || !sizes_ok || key_big;
  assign rd_bit    = mem_rdata[lk[BIT_W-1:0]];
  assign idx_sum   = (AX_W+2*SIZE_W+1)'(px) + (AX_W+2*SIZE_W+1)'(py)
                   + (AX_W+2*SIZE_W+1)'(pz);

  vob_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (lk[BIT_W +: ADDR_W]),
    .rdata (mem_rdata)
  );

  // config registers and derived grid figures
  always_ff @(posedge clk) begin
    if (rst) begin
      org_x    <= '0;
      org_y    <= '0;
      org_z    <= '0;
      size_x   <= SIZE_W'(AXIS_MAX);
      size_y   <= SIZE_W'(AXIS_MAX);
      size_z   <= SIZE_W'(AXIS_MAX);
      settle   <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        settle <= 2'd2;
        case (cfg_index)
          REG_ORIGIN_X: org_x  <= cfg_data;
          REG_ORIGIN_Y: org_y  <= cfg_data;
          REG_ORIGIN_Z: org_z  <= cfg_data;
          REG_SIZE_X:   size_x <= cfg_data[SIZE_W-1:0];
          REG_SIZE_Y:   size_y <= cfg_data[SIZE_W-1:0];
          REG_SIZE_Z:   size_z <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    syz      <= size_y * size_z;
    count    <= (3*SIZE_W)'(size_x) * (3*SIZE_W)'(syz);
    sizes_ok <= (size_x != '0) && (int'(size_x) <= AXIS_MAX)
             && (size_y != '0) && (int'(size_y) <= AXIS_MAX)
             && (size_z != '0) && (int'(size_z) <= AXIS_MAX);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sweep == ADDR_W'(MAP_WORDS - 1)) begin
          state_next = clr_item ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          case (s_axis_tuser)
            FN_CLEAR:     state_next = S_CLEAR;
            FN_QUERY_VOX: state_next = S_SUB;
            default:      state_next = S_LOOK;
          endcase
        end
      end
      S_SUB:   state_next = S_BOUND;
      S_BOUND: state_next = S_SUM;
      S_SUM:   state_next = S_LOOK;
      S_LOOK:  state_next = S_READ;
      S_READ:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE) && (settle == 2'd0);
    mem_we        = 1'b0;
    mem_waddr     = lk[BIT_W +: ADDR_W];
    mem_wdata     = mem_rdata | (WORD_BITS'(1) << lk[BIT_W-1:0]);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        mem_wdata = '0;
      end
      S_READ: begin
        mem_we = (func == FN_MARK) && sizes_ok && !key_big;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      sweep         <= '0;
      clr_item      <= 1'b0;
      map_ready     <= 1'b0;
      load_failed   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          sweep <= sweep + ADDR_W'(1);
        end
        S_IDLE: begin
          if (in_beat && s_axis_tuser == FN_CLEAR) begin
            sweep       <= '0;
            clr_item    <= 1'b1;
            load_failed <= !sizes_ok;
            map_ready   <= sizes_ok && s_axis_tlast;
          end
        end
        S_READ: begin
          if (func == FN_MARK) begin
            load_failed <= fail_new;
            if (last && !fail_new) begin
              map_ready <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            clr_item <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          func       <= s_axis_tuser;
          key        <= s_axis_tdata[21:0];
          last       <= s_axis_tlast;
          vx         <= s_axis_tdata[53:22];
          vy         <= s_axis_tdata[85:54];
          vz         <= s_axis_tdata[117:86];
          lk         <= s_axis_tdata[KEY_W-1:0];
          key_big    <= (3*SIZE_W)'(s_axis_tdata[21:0]) >= count;
          res_occ    <= 1'b0;
          res_status <= sizes_ok ? STS_OK : STS_BAD_CFG;
          res_lkey   <= s_axis_tdata[KEY_W-1:0];
        end
      end
      S_SUB: begin
        rel_x <= (COORD_W+1)'(vx) - (COORD_W+1)'(org_x);
        rel_y <= (COORD_W+1)'(vy) - (COORD_W+1)'(org_y);
        rel_z <= (COORD_W+1)'(vz) - (COORD_W+1)'(org_z);
      end
      S_BOUND: begin
        in_range <= !rel_x[COORD_W] && !rel_y[COORD_W] && !rel_z[COORD_W]
                 && (rel_x < (COORD_W+1)'(size_x))
                 && (rel_y < (COORD_W+1)'(size_y))
                 && (rel_z < (COORD_W+1)'(size_z));
        px <= rel_x[AX_W-1:0] * syz;
        py <= rel_y[AX_W-1:0] * size_z;
        pz <= rel_z[AX_W-1:0];
      end
      S_SUM: begin
        lk <= idx_sum[KEY_W-1:0];
      end
      S_READ: begin
        if (func == FN_MARK) begin
          res_occ  <= 1'b0;
          res_lkey <= key[KEY_W-1:0];
          if (!sizes_ok) begin
            res_status <= STS_BAD_CFG;
          end else if (key_big) begin
            res_status <= STS_KEY_RANGE;
          end else begin
            res_status <= STS_OK;
          end
        end else if (!sizes_ok || !map_ready) begin
          res_occ    <= 1'b0;
          res_status <= !sizes_ok ? STS_BAD_CFG : STS_NOT_READY;
          res_lkey   <= (func == FN_QUERY_VOX) ? '0 : key[KEY_W-1:0];
        end else if (func == FN_QUERY_KEY) begin
          res_occ    <= !key_big && rd_bit;
          res_status <= key_big ? STS_KEY_RANGE : STS_OK;
          res_lkey   <= key[KEY_W-1:0];
        end else begin
          res_occ    <= in_range && rd_bit;
          res_status <= in_range ? STS_OK : STS_OUTSIDE;
          res_lkey   <= in_range ? lk : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {2'b00, res_lkey, res_occ};
      m_axis_tuser <= res_status;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_axis_tready)
    else $error("input beat taken while an item is in flight");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR) || (state == S_READ && func == FN_MARK))
    else $error("bitmap written outside clear sweep or mark");

  a_ready_clean: assert property (@(posedge clk) disable iff (rst)
    $rose(map_ready) |-> !load_failed)
    else $error("map became ready with failure latched");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised outside done state");

endmodule

// ----- rtl/vob_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vob_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
